@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the array delete compactor.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while the active-low reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while the active-low reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

@@ rtl/adc_pkg.sv @@
// Package of the array delete compactor: operation and status codes,
// controller states and the control word that steers the row of cells.
// No dependencies.
package adc_pkg;

    localparam int OP_W     = 3;
    localparam int POS_W    = 4;
    localparam int IN_VAL_W = 32;
    localparam int STAT_W   = 3;
    localparam int OUT_VAL_W = 32;
    localparam int OUT_POS_W = 4;
    localparam int COUNT_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND    = 3'd0,
        OP_DEL_LAST  = 3'd1,
        OP_DEL_FIRST = 3'd2,
        OP_DEL_AT    = 3'd3,
        OP_DEL_MATCH = 3'd4,
        OP_DEL_ALL   = 3'd5,
        OP_READ      = 3'd6,
        OP_NONE      = 3'd7
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_EMPTY     = 3'd1,
        STAT_BAD_POS   = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_FULL      = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DELETE,
        ST_SORT,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        CM_HOLD,
        CM_ROTATE,
        CM_SHIFT,
        CM_APPEND,
        CM_MARK,
        CM_SORT
    } t_cell_mode;

    typedef struct packed {
        t_cell_mode mode;
        logic       phase;
    } t_cell_ctrl;

endpackage

@@ rtl/adc_in_if.sv @@
// Request channel of the array delete compactor: valid/ready plus payload.
// Depends on adc_pkg for the field widths.
interface adc_in_if import adc_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [OP_W-1:0]            op;
    logic [POS_W-1:0]           position;
    logic signed [IN_VAL_W-1:0] match_value;

    modport source (output valid, op, position, match_value, input ready);
    modport sink   (input valid, op, position, match_value, output ready);
endinterface

@@ rtl/adc_out_if.sv @@
// Result channel of the array delete compactor: valid/ready plus payload.
// Depends on adc_pkg for the field widths.
interface adc_out_if import adc_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic [STAT_W-1:0]           status;
    logic signed [OUT_VAL_W-1:0] item_value;
    logic [OUT_POS_W-1:0]        item_position;
    logic [COUNT_W-1:0]          removed_count;
    logic [COUNT_W-1:0]          new_size;

    modport source (output valid, status, item_value, item_position, removed_count,
                    new_size, input ready);
    modport sink   (input valid, status, item_value, item_position, removed_count,
                    new_size, output ready);
endinterface

@@ rtl/adc_cell.sv @@
// One cell of the entry row: holds a word, a hole flag and a count bit,
// and exchanges them with its neighbors as the control word directs. Uses adc_pkg.
module adc_cell import adc_pkg::*; #(
    parameter int DEPTH      = 16,
    parameter int WORD_WIDTH = 32,
    parameter int IDX        = 0
) (
    input  logic                         i_clk,
    input  t_cell_ctrl                   i_ctrl,
    input  logic [$clog2(DEPTH)-1:0]     i_target,
    input  logic [$clog2(DEPTH+1)-1:0]   i_fill,
    input  logic [WORD_WIDTH-1:0]        i_value,
    input  logic [WORD_WIDTH-1:0]        i_right_word,
    input  logic                         i_right_hole,
    input  logic                         i_right_cbit,
    input  logic [WORD_WIDTH-1:0]        i_left_word,
    input  logic                         i_left_hole,
    output logic [WORD_WIDTH-1:0]        o_word,
    output logic                         o_hole,
    output logic                         o_cbit
);

    localparam bit IDX_ODD = (IDX % 2) == 1;

    logic [WORD_WIDTH-1:0] r_word, n_word;
    logic                  r_hole, n_hole;
    logic                  r_cbit, n_cbit;
    logic                  w_is_left;
    logic                  w_below_fill;
    logic                  w_equal;

    assign w_is_left    = (IDX_ODD == i_ctrl.phase);
    assign w_below_fill = 32'(IDX) < 32'(i_fill);
    assign w_equal      = (r_word == i_value);

    always_comb begin
        n_word = r_word;
        n_hole = r_hole;
        n_cbit = r_cbit;
        unique case (i_ctrl.mode)
            CM_HOLD: begin
            end
            CM_ROTATE: begin
                n_word = i_right_word;
            end
            CM_SHIFT: begin
                if (32'(IDX) >= 32'(i_target)) begin
                    n_word = i_right_word;
                end
            end
            CM_APPEND: begin
                if (32'(IDX) == 32'(i_fill)) begin
                    n_word = i_value;
                end
            end
            CM_MARK: begin
                n_hole = !w_below_fill || w_equal;
                n_cbit = w_below_fill && w_equal;
            end
            CM_SORT: begin
                // Holes move right past kept words, one pair exchange per round.
                n_cbit = i_right_cbit;
                if (w_is_left) begin
                    if (r_hole && !i_right_hole) begin
                        n_word = i_right_word;
                        n_hole = i_right_hole;
                    end
                end else begin
                    if (i_left_hole && !r_hole) begin
                        n_word = i_left_word;
                        n_hole = i_left_hole;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_hole <= n_hole;
        r_cbit <= n_cbit;
    end

    assign o_word = r_word;
    assign o_hole = r_hole;
    assign o_cbit = r_cbit;

endmodule

@@ rtl/array_delete_compactor.sv @@
// Append, op seven and rejected requests go from accept straight to the done state, which
// loads the result register; read and single deletes rotate the row in the scan state, the
// deletes but delete-last then pass the delete state, and delete-all runs the sort state.
// One request is in work at a time; the next is taken the cycle after its result is loaded.
// Reset clears the fill count and control only; entries are not cleared, no clearing pass.
module array_delete_compactor import adc_pkg::*; #(
    parameter int DEPTH      = 16,
    parameter int WORD_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    adc_in_if.sink    i_req,
    adc_out_if.source o_res
);

    localparam int IW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);

    // The entries live in a row of DEPTH cells. Cell 0 is the head of the row.
    // A request that needs one entry's value (read, delete last/first/at position,
    // delete first match) rotates the row left through one full turn, so every entry
    // passes the head in index order and is inspected there with the scan counter as
    // its index. After a full turn the row is back in place; every delete but delete-last
    // then runs the delete state, in which every cell at or above the target takes its
    // right neighbor's word.
    // Delete-all marks every entry that matches (and every slot at or above the fill count)
    // as a hole in the accept cycle, then runs DEPTH rounds of odd-even exchange, which
    // moves the holes to the tail while keeping the kept entries in order. The count
    // bits shift out through the head at the same time and are summed.

    t_state                      r_state, n_state;
    logic [FW-1:0]               r_fill, n_fill;
    logic [IW-1:0]               r_k, n_k;
    t_op                         r_op, n_op;
    logic [WORD_WIDTH-1:0]       r_val, n_val;
    logic [IW-1:0]               r_target, n_target;
    logic                        r_found, n_found;
    logic [OUT_VAL_W-1:0]        r_item, n_item;
    t_status                     r_status, n_status;
    logic [FW-1:0]               r_rem, n_rem;

    logic                        r_out_valid, n_out_valid;
    t_status                     r_out_status, n_out_status;
    logic [OUT_VAL_W-1:0]        r_out_item, n_out_item;
    logic [OUT_POS_W-1:0]        r_out_pos, n_out_pos;
    logic [COUNT_W-1:0]          r_out_rem, n_out_rem;
    logic [COUNT_W-1:0]          r_out_size, n_out_size;

    t_cell_ctrl                  w_ctrl;
    logic [WORD_WIDTH-1:0]       w_cell_value;
    logic [WORD_WIDTH-1:0]       w_word [DEPTH];
    logic                        w_hole [DEPTH];
    logic                        w_cbit [DEPTH];

    logic signed [63:0]          w_in_ext;
    logic [WORD_WIDTH-1:0]       w_in_val;
    logic signed [63:0]          w_head_ext;
    logic [OUT_VAL_W-1:0]        w_head_item;
    logic                        w_hit;
    logic                        w_last;
    logic                        w_accept;
    logic                        w_out_load;
    logic                        w_out_fail;
    logic                        w_out_clean;

    // Incoming value is sign-extended from 32 bits and then cut to the word width;
    // an outgoing entry is sign-extended from the word width and cut to 32 bits.
    assign w_in_ext    = 64'(i_req.match_value);
    assign w_in_val    = w_in_ext[WORD_WIDTH-1:0];
    assign w_head_ext  = 64'(signed'(w_word[0]));
    assign w_head_item = w_head_ext[OUT_VAL_W-1:0];

    assign w_hit    = (FW'(r_k) < r_fill) && (w_word[0] == r_val);
    assign w_last   = (r_k == IW'(DEPTH - 1));
    assign w_accept = i_req.valid && i_req.ready;

    // In the accept cycle the cells see the incoming value (append and marking).
    assign w_cell_value = (r_state == ST_IDLE) ? w_in_val : r_val;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WORD_WIDTH-1:0] w_rw;
        logic                  w_rh;
        logic                  w_rc;
        logic [WORD_WIDTH-1:0] w_lw;
        logic                  w_lh;

        // The tail wraps to the head for rotation; the ends act as kept words
        // (left of the head) and holes (right of the tail) so no exchange crosses them.
        if (g == DEPTH - 1) begin : g_tail
            assign w_rw = w_word[0];
            assign w_rh = 1'b1;
            assign w_rc = 1'b0;
        end else begin : g_mid
            assign w_rw = w_word[g+1];
            assign w_rh = w_hole[g+1];
            assign w_rc = w_cbit[g+1];
        end
        if (g == 0) begin : g_head
            assign w_lw = w_word[0];
            assign w_lh = 1'b0;
        end else begin : g_body
            assign w_lw = w_word[g-1];
            assign w_lh = w_hole[g-1];
        end

        adc_cell #(
            .DEPTH      (DEPTH),
            .WORD_WIDTH (WORD_WIDTH),
            .IDX        (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_target     (r_target),
            .i_fill       (r_fill),
            .i_value      (w_cell_value),
            .i_right_word (w_rw),
            .i_right_hole (w_rh),
            .i_right_cbit (w_rc),
            .i_left_word  (w_lw),
            .i_left_hole  (w_lh),
            .o_word       (w_word[g]),
            .o_hole       (w_hole[g]),
            .o_cbit       (w_cbit[g])
        );
    end

    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_k          = r_k;
        n_op         = r_op;
        n_val        = r_val;
        n_target     = r_target;
        n_found      = r_found;
        n_item       = r_item;
        n_status     = r_status;
        n_rem        = r_rem;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_item   = r_out_item;
        n_out_pos    = r_out_pos;
        n_out_rem    = r_out_rem;
        n_out_size   = r_out_size;
        w_ctrl       = '{mode: CM_HOLD, phase: 1'b0};

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_op     = t_op'(i_req.op);
                    n_val    = w_in_val;
                    n_k      = '0;
                    n_target = '0;
                    n_found  = 1'b0;
                    n_item   = '0;
                    n_rem    = '0;
                    n_status = STAT_OK;
                    n_state  = ST_DONE;
                    unique case (t_op'(i_req.op))
                        OP_APPEND: begin
                            if (32'(r_fill) >= DEPTH) begin
                                n_status = STAT_FULL;
                            end else begin
                                w_ctrl.mode = CM_APPEND;
                                n_fill      = r_fill + FW'(1);
                            end
                        end
                        OP_DEL_LAST, OP_DEL_FIRST: begin
                            if (r_fill == '0) begin
                                n_status = STAT_EMPTY;
                            end else begin
                                if (t_op'(i_req.op) == OP_DEL_LAST) begin
                                    n_target = IW'(r_fill - FW'(1));
                                end
                                n_state = ST_SCAN;
                            end
                        end
                        OP_DEL_AT, OP_READ: begin
                            if (r_fill == '0) begin
                                n_status = STAT_EMPTY;
                            end else if (32'(i_req.position) >= 32'(r_fill)) begin
                                n_status = STAT_BAD_POS;
                            end else begin
                                n_target = IW'(i_req.position);
                                n_state  = ST_SCAN;
                            end
                        end
                        OP_DEL_MATCH: begin
                            if (r_fill == '0) begin
                                n_status = STAT_NOT_FOUND;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        OP_DEL_ALL: begin
                            w_ctrl.mode = CM_MARK;
                            n_state     = ST_SORT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // The entry with index r_k sits in the head cell this cycle.
                w_ctrl.mode = CM_ROTATE;
                n_k         = r_k + IW'(1);
                if (r_op == OP_DEL_MATCH) begin
                    if (!r_found && w_hit) begin
                        n_found  = 1'b1;
                        n_target = r_k;
                        n_item   = w_head_item;
                    end
                end else if (r_k == r_target) begin
                    n_item = w_head_item;
                end
                if (w_last) begin
                    n_k = '0;
                    case (r_op)
                        OP_DEL_LAST: begin
                            n_fill  = r_fill - FW'(1);
                            n_rem   = FW'(1);
                            n_state = ST_DONE;
                        end
                        OP_READ: begin
                            n_state = ST_DONE;
                        end
                        OP_DEL_MATCH: begin
                            if (n_found) begin
                                n_rem   = FW'(1);
                                n_state = ST_DELETE;
                            end else begin
                                n_status = STAT_NOT_FOUND;
                                n_state  = ST_DONE;
                            end
                        end
                        default: begin
                            n_rem   = FW'(1);
                            n_state = ST_DELETE;
                        end
                    endcase
                end
            end
            ST_DELETE: begin
                w_ctrl.mode = CM_SHIFT;
                n_fill      = r_fill - FW'(1);
                n_state     = ST_DONE;
            end
            ST_SORT: begin
                w_ctrl.mode  = CM_SORT;
                w_ctrl.phase = r_k[0];
                n_rem        = r_rem + FW'(w_cbit[0]);
                n_k          = r_k + IW'(1);
                if (w_last) begin
                    n_k     = '0;
                    n_fill  = r_fill - n_rem;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_item   = r_item;
                    n_out_pos    = OUT_POS_W'(r_target);
                    n_out_rem    = COUNT_W'(r_rem);
                    n_out_size   = COUNT_W'(r_fill);
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_val        <= n_val;
        r_target     <= n_target;
        r_found      <= n_found;
        r_item       <= n_item;
        r_status     <= n_status;
        r_rem        <= n_rem;
        r_out_status <= n_out_status;
        r_out_item   <= n_out_item;
        r_out_pos    <= n_out_pos;
        r_out_rem    <= n_out_rem;
        r_out_size   <= n_out_size;
    end

    assign i_req.ready         = (r_state == ST_IDLE);
    assign o_res.valid         = r_out_valid;
    assign o_res.status        = r_out_status;
    assign o_res.item_value    = r_out_item;
    assign o_res.item_position = r_out_pos;
    assign o_res.removed_count = r_out_rem;
    assign o_res.new_size      = r_out_size;

    // Terms for the checks below.
    assign w_out_load  = (r_state == ST_DONE) && (!r_out_valid || o_res.ready);
    assign w_out_fail  = r_out_valid && (r_out_status != STAT_OK);
    assign w_out_clean = (r_out_item == '0) && (r_out_rem == '0);

`include "assert_macros.svh"

    // The fill count never passes the row length.
    `ASSERT_IMPLY(a_fill_bound, i_clk, i_rst_n, 1'b1, 32'(r_fill) <= DEPTH)
    // Every accepted request moves the controller out of the idle state in the next cycle.
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_accept, r_state != ST_IDLE)
    // A finished request lands in the output register and frees the controller.
    `ASSERT_NEXT(a_done_load, i_clk, i_rst_n, w_out_load, r_out_valid && (r_state == ST_IDLE))
    // A failing status never carries a value or a removal.
    `ASSERT_IMPLY(a_fail_clean, i_clk, i_rst_n, w_out_fail, w_out_clean)

endmodule
